// ===== hw/rtl/aes128_pkg.sv =====
// Shared constants and byte functions for the AES-128 encryption pipeline.
// No dependencies.
package aes128_pkg;

  localparam int NumRounds = 10;
  localparam int BlockW    = 128;
  localparam int HalfW     = 64;

  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  localparam logic [7:0] ReducePoly = 8'h1b;

  typedef logic [BlockW-1:0] block_t;

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? ReducePoly : 8'h00);
  endfunction

endpackage

// ===== hw/rtl/aes128_if.sv =====
// Request channels for plaintext in and ciphertext out.
// Depends on nothing.
interface aes128_plain_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_high;
  logic [63:0] plain_low;
  modport source (output valid, plain_high, plain_low, input ready);
  modport sink (input valid, plain_high, plain_low, output ready);
endinterface

interface aes128_cipher_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;
  modport source (output valid, cipher_high, cipher_low, input ready);
  modport sink (input valid, cipher_high, cipher_low, output ready);
endinterface

// ===== hw/rtl/aes128_round.sv =====
// One registered AES round stage with its key schedule step.
// Depends on aes128_pkg.
module aes128_round #(
  parameter logic [7:0] RCON  = 8'h01,
  parameter bit         FINAL = 1'b0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  aes128_pkg::block_t    in_state,
  input  aes128_pkg::block_t    in_key,
  output logic                  out_valid,
  input  logic                  out_ready,
  output aes128_pkg::block_t    out_state,
  output aes128_pkg::block_t    out_key
);

  aes128_pkg::block_t key_next;
  aes128_pkg::block_t state_next;
  logic [7:0] sb [16];
  logic [7:0] mx [16];
  logic [31:0] tw;
  logic [31:0] w0, w1, w2, w3;

  always_comb begin
    w0 = in_key[127:96] ^ tw;
    w1 = in_key[95:64] ^ w0;
    w2 = in_key[63:32] ^ w1;
    w3 = in_key[31:0] ^ w2;
    key_next = {w0, w1, w2, w3};
  end

  assign tw = {aes128_pkg::SBOX[in_key[23:16]] ^ RCON, aes128_pkg::SBOX[in_key[15:8]],
               aes128_pkg::SBOX[in_key[7:0]], aes128_pkg::SBOX[in_key[31:24]]};

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[r + 4*c] = aes128_pkg::SBOX[in_state[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        mx[r + 4*c] = sb[r + 4*c] ^ sb[4*c] ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3]
                      ^ aes128_pkg::xtime(sb[r + 4*c] ^ sb[(r + 1) % 4 + 4*c]);
      end
    end
    for (int i = 0; i < 16; i++) begin
      state_next[127 - 8*i -: 8] = (FINAL ? sb[i] : mx[i]) ^ key_next[127 - 8*i -: 8];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_state <= state_next;
      out_key   <= key_next;
    end
  end

endmodule

// ===== hw/rtl/aes128_block_encrypt.sv =====
// AES-128 block encryption, one round per pipeline stage.
// Depends on aes128_pkg, aes128_if, aes128_round.
//
//   channel  dir  payload                   handshake
//   plain    in   plain_high, plain_low     valid/ready
//   cipher   out  cipher_high, cipher_low   valid/ready
//   cfg      in   cfg_index, cfg_data       cfg_we
//
// Key add stage plus ten round stages; one block per cycle unless the cipher channel stalls.
// Each stage carries its own round key, derived from the previous stage's.
// Reset clears the key and all stage valid bits.
// A stage holds while its successor is full and stalled; bubbles are squeezed out.
module aes128_block_encrypt (
  input  logic               clk,
  input  logic               rst,
  aes128_plain_if.sink       plain,
  aes128_cipher_if.source    cipher,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic                v     [aes128_pkg::NumRounds + 1];
  logic                rdy   [aes128_pkg::NumRounds + 1];
  aes128_pkg::block_t  state [aes128_pkg::NumRounds + 1];
  aes128_pkg::block_t  rkey  [aes128_pkg::NumRounds + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aes128_pkg::CFG_KEY_HIGH: key_high <= cfg_data;
        aes128_pkg::CFG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rdy[0]      = !v[0] || rdy[1];
  assign plain.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (rdy[0]) begin
      v[0] <= plain.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && plain.valid) begin
      state[0] <= {plain.plain_high, plain.plain_low} ^ {key_high, key_low};
      rkey[0]  <= {key_high, key_low};
    end
  end

  for (genvar r = 1; r <= aes128_pkg::NumRounds; r++) begin : g_round
    logic down_ready;
    if (r == aes128_pkg::NumRounds) begin : g_last
      assign down_ready = cipher.ready;
    end else begin : g_mid
      assign down_ready = rdy[r+1];
    end
    aes128_round #(
      .RCON  (aes128_pkg::RCON[r-1]),
      .FINAL (r == aes128_pkg::NumRounds)
    ) u_round (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[r-1]),
      .in_ready  (rdy[r]),
      .in_state  (state[r-1]),
      .in_key    (rkey[r-1]),
      .out_valid (v[r]),
      .out_ready (down_ready),
      .out_state (state[r]),
      .out_key   (rkey[r])
    );
  end

  assign cipher.valid       = v[aes128_pkg::NumRounds];
  assign cipher.cipher_high = state[aes128_pkg::NumRounds][127:64];
  assign cipher.cipher_low  = state[aes128_pkg::NumRounds][63:0];

`ifndef NO_ASSERTIONS
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (plain.valid && plain.ready) |=> v[0])
    else $error("accepted request did not enter first stage");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (v[aes128_pkg::NumRounds] && !cipher.ready && v[aes128_pkg::NumRounds-1])
      |=> v[aes128_pkg::NumRounds-1] && $stable(state[aes128_pkg::NumRounds-1]))
    else $error("stage before output lost data during stall");

  a_noready: assert property (@(posedge clk) disable iff (rst)
    (v[0] && !rdy[1]) |-> !plain.ready)
    else $error("input accepted into a blocked first stage");
`endif

endmodule

// ===== sim/tb_channels.sv =====
// Testbench-side view of the plaintext and ciphertext request channels.
// Reuses the RTL interfaces aes128_plain_if and aes128_cipher_if; declares only the latency constant.
package tb_channels_pkg;
  localparam int unsigned LatencyCycles = 11;
endpackage

// ===== sim/testbench.sv =====
// Self-checking testbench for aes128_block_encrypt: an AES-128 predictor
// computes each ciphertext; random stalls on both channels. Depends on aes128_pkg,
// aes128_if and tb_channels_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;

  aes128_plain_if plain ();
  aes128_cipher_if cipher ();

  aes128_block_encrypt DUT (
    .clk(clk), .rst(rst), .plain(plain), .cipher(cipher),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [63:0] key_hi_m = '0, key_lo_m = '0;
  logic [127:0] cipher_queue [$];
  int unsigned errors = 0, sent = 0, received = 0, cycles = 0;
  int unsigned hold_off = 0;
  bit rx_random = 1'b1;

  function automatic logic [7:0] mul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] encrypt_block(input logic [127:0] key,
                                                 input logic [127:0] pt);
    logic [7:0] rk [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] w [4];
    logic [7:0] f, a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127-8*i -: 8];
      s[i] = pt[127-8*i -: 8];
    end
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) w[j] = rk[4*(i-1)+j];
      if (i % 4 == 0) begin
        f = w[0];
        w[0] = aes128_pkg::SBOX[w[1]] ^ aes128_pkg::RCON[i/4-1];
        w[1] = aes128_pkg::SBOX[w[2]];
        w[2] = aes128_pkg::SBOX[w[3]];
        w[3] = aes128_pkg::SBOX[f];
      end
      for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ w[j];
    end
    for (int i = 0; i < 16; i++) s[i] ^= rk[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int rr = 0; rr < 4; rr++) t[rr+4*c] = aes128_pkg::SBOX[s[rr+4*((c+rr)%4)]];
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[4*c] = a0 ^ all ^ mul2(a0 ^ a1);
          t[4*c+1] = a1 ^ all ^ mul2(a1 ^ a2);
          t[4*c+2] = a2 ^ all ^ mul2(a2 ^ a3);
          t[4*c+3] = a3 ^ all ^ mul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*rnd+i];
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver with random stalls plus an optional long hold-off
  initial cipher.ready = 1'b0;
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      cipher.ready <= 1'b0;
    end else if (rx_random) begin
      cipher.ready <= ($urandom_range(0, 99) < 70);
    end else begin
      cipher.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [127:0] want;
    cycles <= cycles + 1;
    if (!rst && cipher.valid && cipher.ready) begin
      received <= received + 1;
      if (cipher_queue.size() == 0) begin
        $display("%0t: unexpected result %h %h", $time, cipher.cipher_high, cipher.cipher_low);
        errors++;
      end else begin
        want = cipher_queue.pop_front();
        if (cipher.cipher_high !== want[127:64]) begin
          $display("%0t: cipher_high expected %h actual %h", $time, want[127:64],
                   cipher.cipher_high);
          errors++;
        end
        if (cipher.cipher_low !== want[63:0]) begin
          $display("%0t: cipher_low expected %h actual %h", $time, want[63:0],
                   cipher.cipher_low);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_request(input logic [63:0] hi, input logic [63:0] lo, input bit gaps);
    int unsigned g;
    g = gaps ? gap_len() : 0;
    repeat (g) begin
      @(negedge clk);
      plain.valid <= 1'b0;
    end
    @(negedge clk);
    plain.valid <= 1'b1;
    plain.plain_high <= hi;
    plain.plain_low <= lo;
    cipher_queue.push_back(encrypt_block({key_hi_m, key_lo_m}, {hi, lo}));
    do @(posedge clk); while (!plain.ready);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    plain.valid <= 1'b0;
    while (cipher_queue.size() != 0) @(posedge clk);
    repeat (tb_channels_pkg::LatencyCycles + 4) @(posedge clk);
  endtask

  task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= aes128_pkg::CFG_KEY_HIGH; cfg_data <= hi;
    @(negedge clk);
    cfg_index <= aes128_pkg::CFG_KEY_LOW; cfg_data <= lo;
    @(negedge clk);
    cfg_we <= 1'b0;
    key_hi_m = hi;
    key_lo_m = lo;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_reset_key();
    send_request('0, '0, 1'b0);
    send_request('1, '1, 1'b0);
    drain();
  endtask

  task automatic test_standard_vector();
    write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_request(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    drain();
    write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_request(64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b0);
    drain();
  endtask

  task automatic test_extremes();
    write_key('1, '1);
    send_request('0, '0, 1'b0);
    send_request('1, '1, 1'b0);
    for (int b = 0; b < 8; b++) send_request(64'h1 << (b * 8 + b), ~(64'h1 << (b * 9)), 1'b0);
    drain();
    write_key('0, '1);
    send_request(64'h8000000000000000, 64'h1, 1'b0);
    send_request(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, 1'b0);
    drain();
    write_key('1, '0);
    send_request(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, 1'b0);
    drain();
  endtask

  task automatic test_back_pressure();
    write_key(rand64(), rand64());
    hold_off = 200;
    for (int i = 0; i < 60; i++) send_request(rand64(), rand64(), 1'b0);
    drain();
  endtask

  task automatic test_random_keys();
    for (int ph = 0; ph < 15; ph++) begin
      write_key(rand64(), rand64());
      rx_random = (ph % 4 != 3);
      for (int i = 0; i < 125; i++) send_request(rand64(), rand64(), (ph % 4 != 3));
      drain();
    end
    rx_random = 1'b1;
  endtask

  initial begin
    plain.valid = 1'b0;
    plain.plain_high = '0;
    plain.plain_low = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_key();
    test_standard_vector();
    test_extremes();
    test_back_pressure();
    test_random_keys();
    $display("covered %0d blocks, %0d ciphertexts, 22 keys incl. all-zero/all-one,", sent,
             received);
    $display("known-answer vectors, long receiver hold-off and random stalls");
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
